// File: rtl/cfrdr_pkg.sv
// Shared types and constants of the CAN receive demultiplexer with byte rings.
package cfrdr_pkg;

    // Number of identifier registers on the configuration port.
    localparam int NUM_ID_REGS = 3;

    localparam int ID_W    = 11;
    localparam int LEN_W   = 4;
    localparam int CH_W    = 2;
    localparam int BYTES_W = 64;
    localparam int CFG_W   = 11;

    // Most payload bytes a frame carries or a read returns.
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 4'd8;

    // Configuration register indexes.
    localparam logic [CH_W-1:0] REG_ID_CHANNEL0 = 2'd0;
    localparam logic [CH_W-1:0] REG_ID_CHANNEL1 = 2'd1;
    localparam logic [CH_W-1:0] REG_ID_CHANNEL2 = 2'd2;

    // Identifier reset values.
    localparam logic [ID_W-1:0] ID_CHANNEL0_RESET = 11'h301;
    localparam logic [ID_W-1:0] ID_CHANNEL1_RESET = 11'h350;
    localparam logic [ID_W-1:0] ID_CHANNEL2_RESET = 11'h351;

    // Transaction kinds on the input channel.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// File: rtl/cfrdr_ram.sv
// Generic single-port synchronous RAM with a registered read.
module cfrdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: rtl/can_frame_receive_demux_rings.sv
// Top level of the CAN receive demultiplexer with per-channel byte rings.
//
// The block takes two kinds of transaction on its input channel. A received
// standard frame (kind 0) has its 11-bit identifier compared, in channel
// order, with the identifiers programmed through the configuration port; on
// the first hit its payload bytes (byte zero first, length clamped to 8) are
// appended to that channel's ring, and the result reports the channel. A
// frame that hits no channel changes nothing. A read request (kind 1) names
// a channel and returns up to max_bytes (clamped to 8) of the oldest unread
// bytes, oldest in the low byte lane, with unused lanes zero; a channel at or
// above the number of rings returns nothing. The write pointer wraps with no
// full check, so writing a ring's depth or more of unread bytes overwrites
// old data and makes the unread count appear smaller. Every input
// transaction yields exactly one output transaction. All rings share one
// single-port RAM that moves one byte per clock. A transaction is accepted,
// then its channel and pointers are looked up, then the RAM moves its bytes
// (followed by a drain step for the last read data when there is any), and
// finally the result is loaded into the output register. That last step
// repeats for as long as the output register still holds a result the
// consumer has not taken. The block works on one transaction at a time, but
// the next one is accepted while the previous result still waits in the
// output register. The RAM holds no reset state and needs no clearing pass;
// only bytes that were written are ever read. Configuration writes must be
// made while the block is idle.
module can_frame_receive_demux_rings #(
    parameter int RING_DEPTH = 1024,
    parameter int CHANNELS   = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_write,
    input  logic [cfrdr_pkg::CH_W-1:0]    cfg_index,
    input  logic [cfrdr_pkg::CFG_W-1:0]   cfg_data,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [cfrdr_pkg::ID_W-1:0]    frame_id,
    input  logic [cfrdr_pkg::LEN_W-1:0]   frame_length,
    input  logic [cfrdr_pkg::BYTES_W-1:0] frame_bytes,
    input  logic [cfrdr_pkg::CH_W-1:0]    channel,
    input  logic [cfrdr_pkg::LEN_W-1:0]   max_bytes,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          matched,
    output logic [cfrdr_pkg::CH_W-1:0]    matched_channel,
    output logic [cfrdr_pkg::LEN_W-1:0]   read_count,
    output logic [cfrdr_pkg::BYTES_W-1:0] read_bytes
);

    import cfrdr_pkg::*;

    // The ring count is CHANNELS capped at the number of identifier registers to route to.
    localparam int LIM    = (CHANNELS < NUM_ID_REGS) ? CHANNELS : NUM_ID_REGS;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int MEM_D  = LIM * RING_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);

    // Control state.
    state_t             state_reg,   state_next;
    logic [ID_W-1:0]    id_reg [NUM_ID_REGS];
    logic [PTR_W-1:0]   wr_ptr_reg [LIM];
    logic [PTR_W-1:0]   wr_ptr_next [LIM];
    logic [PTR_W-1:0]   rd_ptr_reg [LIM];
    logic [PTR_W-1:0]   rd_ptr_next [LIM];
    logic               out_valid_reg, out_valid_next;
    logic               rd_pend_reg,   rd_pend_next;

    // Working registers of the transaction in flight.
    logic               kind_reg,    kind_next;
    logic [ID_W-1:0]    fid_reg,     fid_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [BYTES_W-1:0] fbytes_reg,  fbytes_next;
    logic [CH_W-1:0]    ch_reg,      ch_next;
    logic [LEN_W-1:0]   ask_reg,     ask_next;
    logic [CH_W-1:0]    act_ch_reg,  act_ch_next;
    logic               hit_reg,     hit_next;
    logic [LEN_W-1:0]   cnt_reg,     cnt_next;
    logic [LEN_W-1:0]   idx_reg,     idx_next;
    logic [PTR_W-1:0]   ptr_reg,     ptr_next;
    logic [2:0]         rd_lane_reg, rd_lane_next;
    logic [BYTES_W-1:0] data_reg,    data_next;

    // Output register payload.
    logic               matched_reg,  matched_next;
    logic [CH_W-1:0]    mch_reg,      mch_next;
    logic [LEN_W-1:0]   rcount_reg,   rcount_next;
    logic [BYTES_W-1:0] rbytes_reg,   rbytes_next;

    // RAM port.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    // Lookup helpers.
    logic               match_hit;
    logic [CH_W-1:0]    match_ch;
    logic [CH_W-1:0]    sel_ch;
    logic [PTR_W-1:0]   wp_sel;
    logic [PTR_W-1:0]   rp_sel;
    logic [PTR_W:0]     avail;
    logic               ch_ok;
    logic [PTR_W-1:0]   ptr_inc;

    cfrdr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_D)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // First configured identifier that equals the frame identifier wins.
    always_comb
    begin
        match_hit = 1'b0;
        match_ch  = '0;
        for (int n = 0; n < LIM; n++)
        begin
            if (!match_hit && fid_reg == id_reg[n])
            begin
                match_hit = 1'b1;
                match_ch  = CH_W'(n);
            end
        end
    end

    // Pointer lookup for the channel this transaction works on.
    always_comb
    begin
        sel_ch = (kind_reg == KIND_READ) ? ch_reg : match_ch;
        wp_sel = '0;
        rp_sel = '0;
        ch_ok  = 1'b0;
        for (int n = 0; n < LIM; n++)
        begin
            if (sel_ch == CH_W'(n))
            begin
                wp_sel = wr_ptr_reg[n];
                rp_sel = rd_ptr_reg[n];
                ch_ok  = 1'b1;
            end
        end
        if (wp_sel >= rp_sel)
        begin
            avail = {1'b0, wp_sel} - {1'b0, rp_sel};
        end
        else
        begin
            avail = {1'b0, wp_sel} + DEPTH_EXT - {1'b0, rp_sel};
        end
    end

    assign ptr_inc   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign ram_addr  = ADDR_W'(RING_DEPTH * int'(act_ch_reg) + int'(ptr_reg));
    assign ram_wdata = 8'(fbytes_reg >> {idx_reg[2:0], 3'b000});

    // Next state and datapath control.
    always_comb
    begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        out_valid_next = out_valid_reg;
        rd_pend_next  = 1'b0;
        kind_next     = kind_reg;
        fid_next      = fid_reg;
        len_next      = len_reg;
        fbytes_next   = fbytes_reg;
        ch_next       = ch_reg;
        ask_next      = ask_reg;
        act_ch_next   = act_ch_reg;
        hit_next      = hit_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        rd_lane_next  = rd_lane_reg;
        data_next     = data_reg;
        matched_next  = matched_reg;
        mch_next      = mch_reg;
        rcount_next   = rcount_reg;
        rbytes_next   = rbytes_reg;
        ram_we        = 1'b0;
        in_ready      = 1'b0;

        // The consumer takes the held result.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Read data arrives in the cycle after its address.
        if (rd_pend_reg)
        begin
            data_next = data_reg | (BYTES_W'(ram_rdata) << {rd_lane_reg, 3'b000});
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next   = kind;
                    fid_next    = frame_id;
                    len_next    = (frame_length > MAX_PAYLOAD) ? MAX_PAYLOAD : frame_length;
                    fbytes_next = frame_bytes;
                    ch_next     = channel;
                    ask_next    = (max_bytes > MAX_PAYLOAD) ? MAX_PAYLOAD : max_bytes;
                    state_next  = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                idx_next  = '0;
                data_next = '0;
                if (kind_reg == KIND_FRAME)
                begin
                    hit_next    = match_hit;
                    act_ch_next = match_ch;
                    ptr_next    = wp_sel;
                    cnt_next    = match_hit ? len_reg : '0;
                    state_next  = (match_hit && len_reg != '0) ? ST_WRITE : ST_DONE;
                end
                else
                begin
                    hit_next    = 1'b0;
                    act_ch_next = ch_reg;
                    ptr_next    = rp_sel;
                    if (!ch_ok)
                    begin
                        cnt_next = '0;
                    end
                    else if (avail < (PTR_W + 1)'(ask_reg))
                    begin
                        cnt_next = LEN_W'(avail);
                    end
                    else
                    begin
                        cnt_next = ask_reg;
                    end
                    state_next = (ch_ok && avail != '0 && ask_reg != '0) ? ST_READ : ST_DONE;
                end
            end

            ST_WRITE:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_inc;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    for (int n = 0; n < LIM; n++)
                    begin
                        if (act_ch_reg == CH_W'(n))
                        begin
                            wr_ptr_next[n] = ptr_inc;
                        end
                    end
                    state_next = ST_DONE;
                end
            end

            ST_READ:
            begin
                rd_pend_next = 1'b1;
                rd_lane_next = idx_reg[2:0];
                ptr_next     = ptr_inc;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    for (int n = 0; n < LIM; n++)
                    begin
                        if (act_ch_reg == CH_W'(n))
                        begin
                            rd_ptr_next[n] = ptr_inc;
                        end
                    end
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                // The last byte lands in the assembly register this cycle.
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    matched_next   = (kind_reg == KIND_FRAME) && hit_reg;
                    mch_next       = (kind_reg == KIND_FRAME && hit_reg) ? act_ch_reg : '0;
                    rcount_next    = (kind_reg == KIND_READ) ? cnt_reg : '0;
                    rbytes_next    = (kind_reg == KIND_READ) ? data_reg : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            for (int n = 0; n < LIM; n++)
            begin
                wr_ptr_reg[n] <= '0;
                rd_ptr_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
        end
    end

    // Identifier registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg[0] <= ID_CHANNEL0_RESET;
            id_reg[1] <= ID_CHANNEL1_RESET;
            id_reg[2] <= ID_CHANNEL2_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ID_CHANNEL0: id_reg[0] <= cfg_data;
                REG_ID_CHANNEL1: id_reg[1] <= cfg_data;
                REG_ID_CHANNEL2: id_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        fid_reg     <= fid_next;
        len_reg     <= len_next;
        fbytes_reg  <= fbytes_next;
        ch_reg      <= ch_next;
        ask_reg     <= ask_next;
        act_ch_reg  <= act_ch_next;
        hit_reg     <= hit_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        ptr_reg     <= ptr_next;
        rd_lane_reg <= rd_lane_next;
        data_reg    <= data_next;
        matched_reg <= matched_next;
        mch_reg     <= mch_next;
        rcount_reg  <= rcount_next;
        rbytes_reg  <= rbytes_next;
    end

    assign out_valid       = out_valid_reg;
    assign matched         = matched_reg;
    assign matched_channel = mch_reg;
    assign read_count      = rcount_reg;
    assign read_bytes      = rbytes_reg;

endmodule

// File: rtl/cfrdr_checker.sv
// Port-level assertions for the CAN receive demultiplexer and their binding.
module cfrdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        matched,
    input logic [1:0]  matched_channel,
    input logic [3:0]  read_count,
    input logic [63:0] read_bytes
);

    // A result that is not taken holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_bytes)
            && $stable(read_count) && $stable(matched))
        else $error("output transaction changed while stalled");

    // One transaction at a time: no acceptance right after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> read_count <= 4'd8)
        else $error("read count above eight");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> matched_channel == 2'd0)
        else $error("channel reported without a match");

    // Byte lanes beyond the returned count are zero.
    a_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_count < 4'd8 |->
            (read_bytes >> {read_count[2:0], 3'b000}) == 64'd0)
        else $error("stale data above the read count");

endmodule

bind can_frame_receive_demux_rings cfrdr_checker u_cfrdr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .matched         (matched),
    .matched_channel (matched_channel),
    .read_count      (read_count),
    .read_bytes      (read_bytes)
);

// File: dv/can_frame_receive_demux_rings_check.sv
// Checker for the CAN receive demultiplexer: predicts every result and compares it.
module can_frame_receive_demux_rings_check #(
    parameter int RING_DEPTH = 1024,
    parameter int CHANNELS   = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cfrdr_pkg::CH_W-1:0]    cfg_index,
    input  logic [cfrdr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          kind,
    input  logic [cfrdr_pkg::ID_W-1:0]    frame_id,
    input  logic [cfrdr_pkg::LEN_W-1:0]   frame_length,
    input  logic [cfrdr_pkg::BYTES_W-1:0] frame_bytes,
    input  logic [cfrdr_pkg::CH_W-1:0]    channel,
    input  logic [cfrdr_pkg::LEN_W-1:0]   max_bytes,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          matched,
    input  logic [cfrdr_pkg::CH_W-1:0]    matched_channel,
    input  logic [cfrdr_pkg::LEN_W-1:0]   read_count,
    input  logic [cfrdr_pkg::BYTES_W-1:0] read_bytes,
    output int                            mismatches,
    output int                            pending,
    output int                            frames_stored,
    output int                            bytes_returned,
    output int                            overruns
);
    timeunit 1ns;
    timeprecision 1ps;

    import cfrdr_pkg::*;

    localparam int RING_COUNT = (CHANNELS < NUM_ID_REGS) ? CHANNELS : NUM_ID_REGS;

    typedef struct packed {
        logic               matched;
        logic [CH_W-1:0]    matched_channel;
        logic [LEN_W-1:0]   read_count;
        logic [BYTES_W-1:0] read_bytes;
    } demux_result_t;

    logic [7:0]      ring_mem [CHANNELS*RING_DEPTH];
    int              wr_ptr [CHANNELS];
    int              rd_ptr [CHANNELS];
    logic [ID_W-1:0] route_id [NUM_ID_REGS];
    demux_result_t   awaited_results [$];

    // Applies one input transaction to the local copy of the rings and returns
    // the result the block owes for it.
    function automatic demux_result_t predict_result(
        input logic             k,
        input logic [ID_W-1:0]  fid,
        input logic [LEN_W-1:0] flen,
        input logic [63:0]      fbytes,
        input logic [CH_W-1:0]  ch,
        input logic [LEN_W-1:0] ask
    );
        demux_result_t res;
        int            n;
        int            i;
        int            count;
        int            avail_before;
        int            avail_after;
        bit            found;
        res = '0;
        found = 1'b0;
        if (k == KIND_FRAME) begin
            count = int'((flen > MAX_PAYLOAD) ? MAX_PAYLOAD : flen);
            for (n = 0; n < RING_COUNT; n++) begin
                if (!found && fid == route_id[n]) begin
                    found = 1'b1;
                    avail_before = (wr_ptr[n] + RING_DEPTH - rd_ptr[n]) % RING_DEPTH;
                    for (i = 0; i < count; i++) begin
                        ring_mem[n*RING_DEPTH + wr_ptr[n]] = fbytes[8*i +: 8];
                        wr_ptr[n] = (wr_ptr[n] + 1) % RING_DEPTH;
                    end
                    avail_after = (wr_ptr[n] + RING_DEPTH - rd_ptr[n]) % RING_DEPTH;
                    if (avail_after < avail_before)
                        overruns++;
                    frames_stored++;
                    res.matched = 1'b1;
                    res.matched_channel = n[CH_W-1:0];
                end
            end
        end else begin
            if (ch < RING_COUNT) begin
                avail_before = (wr_ptr[ch] + RING_DEPTH - rd_ptr[ch]) % RING_DEPTH;
                count = int'((ask > MAX_PAYLOAD) ? MAX_PAYLOAD : ask);
                if (avail_before < count)
                    count = avail_before;
                for (i = 0; i < count; i++) begin
                    res.read_bytes[8*i +: 8] = ring_mem[ch*RING_DEPTH + rd_ptr[ch]];
                    rd_ptr[ch] = (rd_ptr[ch] + 1) % RING_DEPTH;
                end
                res.read_count = count[LEN_W-1:0];
                bytes_returned += count;
            end
        end
        return res;
    endfunction

    task automatic compare_result(input demux_result_t want);
        if (matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, matched);
            mismatches++;
        end
        if (matched_channel !== want.matched_channel) begin
            $error("matched_channel: expected %0d, got %0d",
                   want.matched_channel, matched_channel);
            mismatches++;
        end
        if (read_count !== want.read_count) begin
            $error("read_count: expected %0d, got %0d", want.read_count, read_count);
            mismatches++;
        end
        if (read_bytes !== want.read_bytes) begin
            $error("read_bytes: expected %h, got %h", want.read_bytes, read_bytes);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            route_id[REG_ID_CHANNEL0] = ID_CHANNEL0_RESET;
            route_id[REG_ID_CHANNEL1] = ID_CHANNEL1_RESET;
            route_id[REG_ID_CHANNEL2] = ID_CHANNEL2_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                wr_ptr[c] = 0;
                rd_ptr[c] = 0;
            end
            awaited_results.delete();
            mismatches = 0;
            pending = 0;
            frames_stored = 0;
            bytes_returned = 0;
            overruns = 0;
        end else begin
            if (cfg_write && cfg_index < NUM_ID_REGS)
                route_id[cfg_index] = cfg_data[ID_W-1:0];
            // The result leaving now always belongs to an older transaction,
            // so it is matched before the newly accepted one is queued.
            if (out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    compare_result(awaited_results.pop_front());
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(predict_result(kind, frame_id, frame_length,
                                                         frame_bytes, channel, max_bytes));
            pending = awaited_results.size();
        end
    end

endmodule

// File: dv/can_frame_receive_demux_rings_test.sv
// Testbench top for the CAN receive demultiplexer: stimulus, flow control and verdict.
module can_frame_receive_demux_rings_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfrdr_pkg::*;

    // Index past the last identifier register; writes to it must be ignored.
    localparam logic [CH_W-1:0] REG_SPARE = 2'd3;

    // Worst case is far below this: roughly 1700 transactions, each held up at most
    // by the block's own work plus the longest sender gap and receiver stall.
    localparam int CYCLE_LIMIT  = 1000000;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 400;
    // Quiet time after the last result, to catch stray result transactions.
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic               kind;
        logic [ID_W-1:0]    frame_id;
        logic [LEN_W-1:0]   frame_length;
        logic [BYTES_W-1:0] frame_bytes;
        logic [CH_W-1:0]    channel;
        logic [LEN_W-1:0]   max_bytes;
    } rx_item_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [CH_W-1:0]    cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [ID_W-1:0]    frame_id;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTES_W-1:0] frame_bytes;
    logic [CH_W-1:0]    channel;
    logic [LEN_W-1:0]   max_bytes;
    logic               out_valid;
    logic               out_ready;
    logic               matched;
    logic [CH_W-1:0]    matched_channel;
    logic [LEN_W-1:0]   read_count;
    logic [BYTES_W-1:0] read_bytes;

    int mismatches;
    int pending;
    int frames_stored;
    int bytes_returned;
    int overruns;

    // The identifiers currently programmed, kept so that random frames can
    // aim at real channels most of the time.
    logic [ID_W-1:0] chan_id [NUM_ID_REGS];

    int cycle_count = 0;
    int frames_sent = 0;
    int reads_sent  = 0;
    int id_settings = 1;

    // Flow-control knobs. A steady side never idles; the hold request makes
    // the receiver stop taking results for the hold-off set by HOLD_CYCLES.
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_request = 1'b0;

    can_frame_receive_demux_rings i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .frame_id        (frame_id),
        .frame_length    (frame_length),
        .frame_bytes     (frame_bytes),
        .channel         (channel),
        .max_bytes       (max_bytes),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .matched         (matched),
        .matched_channel (matched_channel),
        .read_count      (read_count),
        .read_bytes      (read_bytes)
    );

    can_frame_receive_demux_rings_check i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .frame_id        (frame_id),
        .frame_length    (frame_length),
        .frame_bytes     (frame_bytes),
        .channel         (channel),
        .max_bytes       (max_bytes),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .matched         (matched),
        .matched_channel (matched_channel),
        .read_count      (read_count),
        .read_bytes      (read_bytes),
        .mismatches      (mismatches),
        .pending         (pending),
        .frames_stored   (frames_stored),
        .bytes_returned  (bytes_returned),
        .overruns        (overruns)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Watchdog expired after %0d cycles with %0d results outstanding.",
                 cycle_count, pending);
        $display("Simulation FAILED");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic rx_item_t make_frame(input logic [ID_W-1:0] id,
                                            input logic [LEN_W-1:0] len,
                                            input logic [BYTES_W-1:0] payload);
        rx_item_t t;
        t = '{default: '0};
        t.kind = KIND_FRAME;
        t.frame_id = id;
        t.frame_length = len;
        t.frame_bytes = payload;
        return t;
    endfunction

    function automatic rx_item_t make_read(input logic [CH_W-1:0] ch,
                                           input logic [LEN_W-1:0] ask);
        rx_item_t t;
        t = '{default: '0};
        t.kind = KIND_READ;
        t.channel = ch;
        t.max_bytes = ask;
        return t;
    endfunction

    // A random transaction. Every field is filled with noise first, so the
    // fields a kind ignores still toggle, then the relevant ones are shaped.
    // With focus at or above zero, frames all go to that ring, mostly at full
    // length, which is how the ring gets overrun.
    function automatic rx_item_t random_item(input int frame_pct, input int focus);
        rx_item_t t;
        t.frame_id = ID_W'($urandom_range(0, 2047));
        t.frame_length = LEN_W'($urandom_range(0, 15));
        t.frame_bytes = {$urandom, $urandom};
        t.channel = CH_W'($urandom_range(0, 3));
        t.max_bytes = LEN_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < frame_pct) begin
            t.kind = KIND_FRAME;
            if (focus >= 0) begin
                t.frame_id = chan_id[focus];
                if ($urandom_range(0, 9) != 0)
                    t.frame_length = MAX_PAYLOAD;
            end else begin
                if ($urandom_range(0, 3) != 0)
                    t.frame_id = chan_id[$urandom_range(0, NUM_ID_REGS-1)];
                if ($urandom_range(0, 6) != 0)
                    t.frame_length = LEN_W'($urandom_range(0, 8));
            end
        end else begin
            t.kind = KIND_READ;
            if ($urandom_range(0, 9) != 0)
                t.channel = CH_W'($urandom_range(0, 2));
            if ($urandom_range(0, 6) != 0)
                t.max_bytes = LEN_W'($urandom_range(0, 8));
        end
        return t;
    endfunction

    // Offers one transaction after a random gap and returns once the block
    // has taken it. Valid is left high so a back-to-back transaction can
    // follow without a bubble.
    task automatic offer(input rx_item_t t);
        int gap;
        gap = pick_gap(tx_steady);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= t.kind;
        frame_id     <= t.frame_id;
        frame_length <= t.frame_length;
        frame_bytes  <= t.frame_bytes;
        channel      <= t.channel;
        max_bytes    <= t.max_bytes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (t.kind == KIND_FRAME)
            frames_sent++;
        else
            reads_sent++;
    endtask

    // Drops valid and waits until every result has come back, so the block
    // is idle and may be reprogrammed.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Programs all three identifiers, one write per cycle, optionally also
    // hitting the unused index with junk that must change nothing.
    task automatic program_ids(input logic [ID_W-1:0] id0, input logic [ID_W-1:0] id1,
                               input logic [ID_W-1:0] id2, input bit with_spare);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_ID_CHANNEL0;
        cfg_data  <= id0;
        @(negedge clk);
        cfg_index <= REG_ID_CHANNEL1;
        cfg_data  <= id1;
        @(negedge clk);
        cfg_index <= REG_ID_CHANNEL2;
        cfg_data  <= id2;
        if (with_spare) begin
            @(negedge clk);
            cfg_index <= REG_SPARE;
            cfg_data  <= CFG_W'($urandom_range(0, 2047));
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        chan_id[REG_ID_CHANNEL0] = id0;
        chan_id[REG_ID_CHANNEL1] = id1;
        chan_id[REG_ID_CHANNEL2] = id2;
        id_settings++;
    endtask

    task automatic run_random(input int count, input int frame_pct, input int focus);
        repeat (count)
            offer(random_item(frame_pct, focus));
    endtask

    // Receiver: random stalls, plus one long hold-off on request. The
    // hold-off is counted here so the sender keeps pushing meanwhile.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end else begin
                stall = pick_gap(rx_steady);
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = KIND_FRAME;
        frame_id     = '0;
        frame_length = '0;
        frame_bytes  = '0;
        channel      = '0;
        max_bytes    = '0;
        chan_id[REG_ID_CHANNEL0] = ID_CHANNEL0_RESET;
        chan_id[REG_ID_CHANNEL1] = ID_CHANNEL1_RESET;
        chan_id[REG_ID_CHANNEL2] = ID_CHANNEL2_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the identifiers at their reset values. It walks
        // the corners: an empty ring, zero-length and full frames, a frame
        // longer than eight bytes, requests of zero and of more than eight
        // bytes, requests larger than what is stored, frames that hit no
        // channel, and a read of the channel that does not exist.
        offer(make_read(2'd0, 4'd8));
        offer(make_frame(ID_CHANNEL0_RESET, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        offer(make_frame(ID_CHANNEL0_RESET, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        offer(make_frame(ID_CHANNEL0_RESET, 4'd15, 64'h0123_4567_89AB_CDEF));
        offer(make_read(2'd0, 4'd0));
        offer(make_read(2'd0, 4'd15));
        offer(make_read(2'd0, 4'd3));
        offer(make_read(2'd0, 4'd8));
        offer(make_frame(ID_CHANNEL1_RESET, 4'd5, 64'hAAAA_AAAA_AAAA_AAAA));
        offer(make_frame(ID_CHANNEL2_RESET, 4'd8, 64'h5555_5555_5555_5555));
        offer(make_frame(11'h000, 4'd8, 64'h1122_3344_5566_7788));
        offer(make_frame(11'h7FF, 4'd8, 64'h8877_6655_4433_2211));
        offer(make_frame(11'h300, 4'd8, 64'hDEAD_BEEF_CAFE_F00D));
        offer(make_read(REG_SPARE, 4'd8));
        offer(make_read(2'd1, 4'd8));
        offer(make_read(2'd1, 4'd8));
        offer(make_read(2'd2, 4'd4));
        offer(make_read(2'd2, 4'd9));
        offer(make_frame(ID_CHANNEL2_RESET, 4'd1, 64'h0));
        offer(make_read(2'd2, 4'd1));
        offer(make_read(2'd2, 4'd8));

        // Random traffic at the reset identifiers.
        run_random(300, 50, -1);

        // Identifier extremes, plus a write to the unused index.
        settle();
        program_ids(11'h000, 11'h7FF, 11'h400, 1'b1);
        run_random(300, 55, -1);

        // All three channels share one identifier: only channel zero may ever
        // take a frame. Both sides run without idling in this stretch.
        settle();
        program_ids(11'h155, 11'h155, 11'h155, 1'b0);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random(200, 50, -1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Nearly all transactions are frames, all to ring one and mostly at full length, so
        // more than a ring's depth of unread bytes piles up and wraps.
        settle();
        program_ids(ID_W'($urandom_range(0, 682)), ID_W'($urandom_range(683, 1365)),
                    ID_W'($urandom_range(1366, 2047)), 1'b0);
        run_random(180, 97, 1);

        // Back-pressure: the receiver stops for a long stretch while the
        // sender keeps offering, so the block fills and stalls its input.
        hold_request = 1'b1;
        tx_steady = 1'b1;
        run_random(50, 50, -1);
        tx_steady = 1'b0;

        // Channel two shadowed by channel zero; reads drain what is left.
        settle();
        program_ids(11'h7FF, 11'h000, 11'h7FF, 1'b1);
        run_random(300, 45, -1);

        settle();
        program_ids(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                    ID_W'($urandom_range(0, 2047)), 1'b0);
        run_random(300, 40, -1);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d frames and %0d read requests across %0d identifier settings.",
                 frames_sent, reads_sent, id_settings);
        $display("Stored %0d frames, read back %0d bytes, saw %0d ring overruns.",
                 frames_stored, bytes_returned, overruns);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
